FILE: rtl/bhs_pkg.sv
// Shared types and constants for the bucketed histogram sampler.
// No dependencies; used by bhs_ctrl, bhs_dpath and the top level.
package bhs_pkg;

  localparam int SymbolsDef    = 32;
  localparam int BucketsDef    = 11;
  localparam int CountWidthDef = 16;

  localparam int KindW   = 2;
  localparam int ProbW   = 10;
  localparam int SymW    = 5;
  localparam int RndW    = 31;
  localparam int InDataW  = 48;
  localparam int OutDataW = 8;

  // prob / 100 as (prob * 41) >> 12, exact for every 10-bit value
  localparam int BucketMul   = 41;
  localparam int BucketShift = 12;

  typedef enum logic [KindW-1:0] {
    KIND_OBSERVE = 2'd0,
    KIND_DRAW    = 2'd1,
    KIND_NEWPOS  = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef enum logic [9:0] {
    ST_CLEAR    = 10'b00_0000_0001,
    ST_IDLE     = 10'b00_0000_0010,
    ST_OBS_RD   = 10'b00_0000_0100,
    ST_OBS_WR   = 10'b00_0000_1000,
    ST_SUM      = 10'b00_0001_0000,
    ST_SUM_END  = 10'b00_0010_0000,
    ST_MOD      = 10'b00_0100_0000,
    ST_WALK     = 10'b00_1000_0000,
    ST_WALK_END = 10'b01_0000_0000,
    ST_EMIT     = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic load;       // capture the accepted item
    logic clr_wr;     // write zero during the clearing pass
    logic rd_sym;     // read the observed symbol's count
    logic obs_wr;     // write back the incremented count
    logic rd_scan;    // read the next count of the bucket
    logic acc_sum;    // add returned counts into the total
    logic mod_start;  // set up remainder and the walk
    logic mod_step;   // one restoring step of the modulo
    logic walk;       // add returned counts into the running sum
    logic emit;       // load the output register
    logic excl_clr;   // clear the exclusion set
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_last;
    logic mod_last;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/bhs_ctrl.sv
// Controller state machine of the bucketed histogram sampler.
// Depends on bhs_pkg; drives bhs_dpath through cmd_t and reads status_t.
module bhs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bhs_pkg::kind_e    kind_i,
  input  bhs_pkg::status_t  status_i,
  output logic              in_ready_o,
  output bhs_pkg::cmd_t     cmd_o
);

  bhs_pkg::state_e state_q, state_d;
  logic            accept;

  assign in_ready_o = (state_q == bhs_pkg::ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      bhs_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = bhs_pkg::ST_IDLE;
      end
      bhs_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (kind_i)
            bhs_pkg::KIND_OBSERVE: state_d = bhs_pkg::ST_OBS_RD;
            bhs_pkg::KIND_DRAW:    state_d = bhs_pkg::ST_SUM;
            bhs_pkg::KIND_NEWPOS:  cmd_o.excl_clr = 1'b1;
            default:               state_d = bhs_pkg::ST_IDLE;
          endcase
        end
      end
      bhs_pkg::ST_OBS_RD: begin
        cmd_o.rd_sym = 1'b1;
        state_d      = bhs_pkg::ST_OBS_WR;
      end
      bhs_pkg::ST_OBS_WR: begin
        cmd_o.obs_wr = 1'b1;
        state_d      = bhs_pkg::ST_IDLE;
      end
      bhs_pkg::ST_SUM: begin
        cmd_o.rd_scan = 1'b1;
        cmd_o.acc_sum = 1'b1;
        if (status_i.idx_last) state_d = bhs_pkg::ST_SUM_END;
      end
      bhs_pkg::ST_SUM_END: begin
        cmd_o.acc_sum   = 1'b1;
        cmd_o.mod_start = 1'b1;
        state_d         = bhs_pkg::ST_MOD;
      end
      bhs_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) state_d = bhs_pkg::ST_WALK;
      end
      bhs_pkg::ST_WALK: begin
        cmd_o.rd_scan = 1'b1;
        cmd_o.walk    = 1'b1;
        if (status_i.idx_last) state_d = bhs_pkg::ST_WALK_END;
      end
      bhs_pkg::ST_WALK_END: begin
        cmd_o.walk = 1'b1;
        state_d    = bhs_pkg::ST_EMIT;
      end
      bhs_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = bhs_pkg::ST_IDLE;
        end
      end
      default: state_d = bhs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/bhs_dpath.sv
// Datapath of the bucketed histogram sampler: count memory, total,
// iterative modulo, running-sum search, exclusion set and output register.
// Depends on bhs_pkg; controlled by bhs_ctrl.
module bhs_dpath #(
  parameter int SYMBOLS     = bhs_pkg::SymbolsDef,
  parameter int BUCKETS     = bhs_pkg::BucketsDef,
  parameter int COUNT_WIDTH = bhs_pkg::CountWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bhs_pkg::cmd_t               cmd_i,
  output bhs_pkg::status_t            status_o,
  input  logic [bhs_pkg::ProbW-1:0]   prob_i,
  input  logic [bhs_pkg::SymW-1:0]    sym_i,
  input  logic [bhs_pkg::RndW-1:0]    rnd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bhs_pkg::SymW-1:0]    out_sym_o,
  output logic                        out_rej_o
);

  localparam int Entries = BUCKETS * SYMBOLS;
  localparam int AW      = $clog2(Entries);
  localparam int SW      = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int TW      = COUNT_WIDTH + SW;
  localparam int CntW    = $clog2(bhs_pkg::RndW);
  localparam int QW      = bhs_pkg::ProbW + 7 - bhs_pkg::BucketShift;

  logic [COUNT_WIDTH-1:0] mem [Entries];

  logic [BW-1:0]               bucket_q;
  logic [bhs_pkg::SymW-1:0]    sym_q;
  logic [bhs_pkg::RndW-1:0]    rnd_q;
  logic [SW-1:0]               idx_q;
  logic [AW-1:0]               clr_addr_q;
  logic [COUNT_WIDTH-1:0]      rd_q;
  logic                        rd_vld_q;
  logic [SW-1:0]               rd_idx_q;
  logic [TW-1:0]               total_q;
  logic [TW:0]                 rem_q;
  logic [CntW-1:0]             bitcnt_q;
  logic [TW-1:0]               run_q;
  logic                        found_q;
  logic [SW-1:0]               pick_q;
  logic [SYMBOLS-1:0]          excl_q;
  logic                        out_valid_q;
  logic [bhs_pkg::SymW-1:0]    out_sym_q;
  logic                        out_rej_q;

  logic [bhs_pkg::ProbW+6:0]   prod;
  logic [QW-1:0]               quot;
  logic [BW-1:0]               bucket_d;
  logic [SW-1:0]               sym_idx;
  logic                        sym_ok;
  logic [AW-1:0]               base_addr;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               waddr;
  logic                        we;
  logic [COUNT_WIDTH-1:0]      wdata;
  logic [TW+1:0]               rem_sh;
  logic [TW+1:0]               divisor;
  logic [TW-1:0]               run_next;
  logic                        hit;

  // bucket = floor(prob / 100), saturated to the last bucket
  assign prod = (bhs_pkg::ProbW + 7)'(prob_i) * (bhs_pkg::ProbW + 7)'(bhs_pkg::BucketMul);
  assign quot = prod[bhs_pkg::ProbW+6:bhs_pkg::BucketShift];
  assign bucket_d = (32'(quot) > BUCKETS - 1) ? BW'(BUCKETS - 1) : BW'(quot);

  assign sym_idx   = SW'(sym_q);
  assign sym_ok    = 32'(sym_q) < SYMBOLS;
  assign base_addr = AW'(bucket_q) * AW'(SYMBOLS);
  assign raddr     = cmd_i.rd_sym ? base_addr + AW'(sym_idx) : base_addr + AW'(idx_q);
  assign we        = cmd_i.clr_wr || (cmd_i.obs_wr && sym_ok);
  assign waddr     = cmd_i.clr_wr ? clr_addr_q : base_addr + AW'(sym_idx);
  assign wdata     = cmd_i.clr_wr ? '0 : ((&rd_q) ? rd_q : rd_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  assign rem_sh   = {rem_q, rnd_q[bhs_pkg::RndW-1]};
  assign divisor  = (TW + 2)'(total_q) + 1'b1;
  assign run_next = run_q + TW'(rd_q);
  assign hit      = excl_q[pick_q];

  // item, scan and arithmetic registers
  always_ff @(posedge clk_i) begin
    rd_vld_q <= cmd_i.rd_scan;
    rd_idx_q <= idx_q;
    if (cmd_i.load) begin
      bucket_q <= bucket_d;
      sym_q    <= sym_i;
      rnd_q    <= rnd_i;
      idx_q    <= '0;
      total_q  <= '0;
    end else begin
      if (cmd_i.rd_scan) idx_q <= idx_q + 1'b1;
      if (cmd_i.acc_sum && rd_vld_q) total_q <= total_q + TW'(rd_q);
      if (cmd_i.mod_start) begin
        rem_q    <= '0;
        bitcnt_q <= '0;
        idx_q    <= '0;
        run_q    <= '0;
        found_q  <= 1'b0;
        pick_q   <= '0;
      end
      if (cmd_i.mod_step) begin
        rem_q    <= (rem_sh >= divisor) ? (TW + 1)'(rem_sh - divisor) : (TW + 1)'(rem_sh);
        rnd_q    <= rnd_q << 1;
        bitcnt_q <= bitcnt_q + 1'b1;
      end
      if (cmd_i.walk && rd_vld_q) begin
        run_q <= run_next;
        if (!found_q && ((TW + 1)'(run_next) >= rem_q)) begin
          found_q <= 1'b1;
          pick_q  <= rd_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      excl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.excl_clr) excl_q <= '0;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (!hit) excl_q[pick_q] <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_sym_q <= bhs_pkg::SymW'(pick_q);
      out_rej_q <= hit;
    end
  end

  assign status_o.clr_last = (clr_addr_q == AW'(Entries - 1));
  assign status_o.idx_last = (idx_q == SW'(SYMBOLS - 1));
  assign status_o.mod_last = (bitcnt_q == CntW'(bhs_pkg::RndW - 1));
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_sym_o   = out_sym_q;
  assign out_rej_o   = out_rej_q;

endmodule

FILE: rtl/bucketed_histogram_sampler.sv
// Top level of the bucketed histogram sampler: stream ports around
// bhs_ctrl and bhs_dpath. Depends on bhs_pkg.
//
// Input stream s_axis: one item per transfer (observe, draw, new position).
// Output stream m_axis: one result per draw item: drawn symbol and reject flag.
// After reset the count memory is swept to zero, one entry a cycle, all
// BUCKETS*SYMBOLS entries (352 by default); s_axis_tready stays low meanwhile.
// Items are taken one at a time; s_axis_tready is high only while idle.
// Observe: read, then saturating write back. New position: clears the exclusion set.
// Draw: a pass over the bucket's counts for the total, 31 restoring steps
// of the modulo, a second pass for the running-sum search, then the output
// register; the single-port count memory read sets the two passes.
// A result sits in the output register until m_axis_tready takes it; the
// next item is accepted meanwhile, and a following draw holds at its end
// while the register is still occupied.
module bucketed_histogram_sampler #(
  parameter int SYMBOLS     = bhs_pkg::SymbolsDef,
  parameter int BUCKETS     = bhs_pkg::BucketsDef,
  parameter int COUNT_WIDTH = bhs_pkg::CountWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] kind, [11:2] prob_tenths, [16:12] symbol, [47:17] random_word
  input  logic [bhs_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [4:0] drawn_symbol, [5] rejected, [7:6] zero
  output logic [bhs_pkg::OutDataW-1:0]   m_axis_tdata
);

  bhs_pkg::cmd_t             cmd;
  bhs_pkg::status_t          status;
  logic [bhs_pkg::SymW-1:0]  out_sym;
  logic                      out_rej;

  bhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .kind_i     (bhs_pkg::kind_e'(s_axis_tdata[1:0])),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  bhs_dpath #(
    .SYMBOLS     (SYMBOLS),
    .BUCKETS     (BUCKETS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .prob_i      (s_axis_tdata[11:2]),
    .sym_i       (s_axis_tdata[16:12]),
    .rnd_i       (s_axis_tdata[47:17]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sym_o   (out_sym),
    .out_rej_o   (out_rej)
  );

  assign m_axis_tdata = {2'b00, out_rej, out_sym};

endmodule

FILE: dv/bhs_checker.sv
// Checker for the bucketed histogram sampler: watches both streams,
// predicts each draw result and compares. Depends on bhs_pkg.
`timescale 1ns / 1ps
module bhs_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  input  logic                         s_ready_i,
  input  logic [bhs_pkg::InDataW-1:0]  s_data_i,
  input  logic                         m_valid_i,
  input  logic                         m_ready_i,
  input  logic [bhs_pkg::OutDataW-1:0] m_data_i,
  output int                           fail_count_o,
  output int                           draws_pending_o
);

  typedef struct packed {
    logic [4:0] sym;
    logic       rejected;
  } draw_t;

  logic [15:0] counts[11][32];
  logic [31:0] excluded;
  draw_t       draw_q[$];

  assign draws_pending_o = draw_q.size();

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic int bucket_sel(input logic [9:0] prob);
    int b;
    b = prob / 100;
    return (b > 10) ? 10 : b;
  endfunction

  task automatic apply_item(input logic [bhs_pkg::InDataW-1:0] d);
    bhs_pkg::kind_e k;
    int          b;
    logic [4:0]  s;
    longint      total, r, run;
    int          pick;
    draw_t       e;
    k = bhs_pkg::kind_e'(d[1:0]);
    b = bucket_sel(d[11:2]);
    s = d[16:12];
    case (k)
      bhs_pkg::KIND_OBSERVE: begin
        if (counts[b][s] != 16'hFFFF) counts[b][s] = counts[b][s] + 1;
      end
      bhs_pkg::KIND_NEWPOS: excluded = '0;
      bhs_pkg::KIND_DRAW: begin
        total = 0;
        for (int j = 0; j < 32; j++) total += counts[b][j];
        r = longint'(d[47:17]) % (total + 1);
        run = 0;
        pick = 0;
        for (int j = 0; j < 32; j++) begin
          run += counts[b][j];
          if (run >= r) begin
            pick = j;
            break;
          end
        end
        e.sym = pick[4:0];
        e.rejected = excluded[pick];
        if (!excluded[pick]) excluded[pick] = 1'b1;
        draw_q = {draw_q, e};
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    draw_t got, want;
    if (!rst_ni) begin
      for (int b = 0; b < 11; b++)
        for (int j = 0; j < 32; j++) counts[b][j] = '0;
      excluded = '0;
      draw_q.delete();
      fail_count_o = 0;
    end else begin
      if (s_valid_i && s_ready_i) apply_item(s_data_i);
      if (m_valid_i && m_ready_i) begin
        got = draw_t'({m_data_i[4:0], m_data_i[5]});
        if (draw_q.size() == 0) begin
          report_mismatch("result with none expected");
        end else begin
          want = draw_q.pop_front();
          if (got.sym != want.sym)
            report_mismatch($sformatf("symbol %0d, want %0d", got.sym, want.sym));
          if (got.rejected != want.rejected)
            report_mismatch($sformatf("rejected %0b, want %0b", got.rejected,
                                      want.rejected));
          if (m_data_i[7:6] != 2'b00) report_mismatch("pad bits not zero");
        end
      end
    end
  end
endmodule

FILE: dv/testbench.sv
// Top of the bucketed histogram sampler testbench: clock, reset, stimulus
// and verdict. Depends on bhs_pkg, bhs_checker and the block.
`timescale 1ns / 1ps
module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [bhs_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [bhs_pkg::OutDataW-1:0] m_axis_tdata;
  int   fail_count, draws_pending;
  int   idle_pct = 31;
  bit   hold_off = 1'b0;
  int   quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  bucketed_histogram_sampler dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  bhs_checker checker_i (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .fail_count_o(fail_count), .draws_pending_o(draws_pending)
  );

  function automatic logic [bhs_pkg::InDataW-1:0] pack_item(bhs_pkg::kind_e k, int prob,
                                                            int sym, logic [30:0] rnd);
    return {rnd, sym[4:0], prob[9:0], k};
  endfunction

  // Send one item; idle at random first.
  task automatic send(input logic [bhs_pkg::InDataW-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid after the last transfer before waiting on results.
  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random();
    int  p, sel;
    bhs_pkg::kind_e k;
    logic [30:0] rnd;
    sel = $urandom_range(99);
    k = sel < 55 ? bhs_pkg::KIND_OBSERVE : sel < 85 ? bhs_pkg::KIND_DRAW
        : sel < 97 ? bhs_pkg::KIND_NEWPOS : bhs_pkg::KIND_UNUSED;
    // Mostly few buckets so the counts grow; sometimes anywhere incl. 1000+.
    p = $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(299);
    rnd = $urandom_range(3) == 0 ? 31'($urandom_range(40)) : 31'($urandom);
    send(pack_item(k, p, $urandom_range(31), rnd));
  endtask

  // Receiver: random stalls, or a counted hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("FAIL bucketed_histogram_sampler");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: empty bucket, extremes of fields, every kind.
    send(pack_item(bhs_pkg::KIND_DRAW, 0, 0, 31'h7FFFFFFF));
    send(pack_item(bhs_pkg::KIND_DRAW, 1023, 31, 31'd0));
    send(pack_item(bhs_pkg::KIND_OBSERVE, 1023, 31, 31'h7FFFFFFF));
    send(pack_item(bhs_pkg::KIND_OBSERVE, 1000, 0, 31'd0));
    send(pack_item(bhs_pkg::KIND_DRAW, 1050, 0, 31'd1));
    send(pack_item(bhs_pkg::KIND_DRAW, 1099, 0, 31'd2));
    send(pack_item(bhs_pkg::KIND_DRAW, 1100, 0, 31'h7FFFFFFF));
    send(pack_item(bhs_pkg::KIND_UNUSED, 555, 21, 31'h2AAAAAAA));
    send(pack_item(bhs_pkg::KIND_NEWPOS, 0, 0, 31'd0));
    send(pack_item(bhs_pkg::KIND_OBSERVE, 99, 5, 31'd0));
    send(pack_item(bhs_pkg::KIND_OBSERVE, 100, 10, 31'd0));
    send(pack_item(bhs_pkg::KIND_DRAW, 99, 0, 31'd1));
    send(pack_item(bhs_pkg::KIND_DRAW, 99, 0, 31'd1));
    send(pack_item(bhs_pkg::KIND_DRAW, 100, 0, 31'd0));
    send(pack_item(bhs_pkg::KIND_DRAW, 199, 0, 31'h55555555));
    // Back to back until the random part.
    idle_pct = 0;
    send(pack_item(bhs_pkg::KIND_DRAW, 950, 0, 31'h7FFFFFFF));
    send(pack_item(bhs_pkg::KIND_DRAW, 950, 0, 31'd65535));
    // Observe each symbol of bucket 5 once, then draw until all are excluded and the rest are rejected.
    for (int j = 0; j < 32; j++) send(pack_item(bhs_pkg::KIND_OBSERVE, 500, j, 31'd0));
    send(pack_item(bhs_pkg::KIND_NEWPOS, 0, 0, 31'd0));
    for (int j = 0; j < 40; j++) send(pack_item(bhs_pkg::KIND_DRAW, 500, 0, 31'(j)));
    // Random part, with a stretch free of idling.
    for (int i = 0; i < 1760; i++) begin
      idle_pct = (i >= 600 && i < 850) ? 0 : 31;
      if (i == 300) begin
        // Sender pauses until every draw result has arrived.
        pause_sender();
        wait (draws_pending == 0);
      end
      if (i == 1000) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (1500) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      send_random();
    end
    pause_sender();
    hold_off = 1'b0;
    wait (draws_pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("PASS bucketed_histogram_sampler");
    else $display("FAIL bucketed_histogram_sampler");
    $finish;
  end
endmodule
